[sv/rwps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_pkg
// Shared types and constants for the rounded window pixel shader: the
// configuration register map and the field widths.
// ----------------------------------------------------------------------------
package rwps_pkg;

    // Field widths.
    localparam int COORD_W  = 12;
    localparam int RADIUS_W = 11;
    localparam int COLOR_W  = 32;
    localparam int CFG_IDX_W = 3;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_LEFT      = 3'd0,
        REG_WIN_TOP       = 3'd1,
        REG_WIN_WIDTH     = 3'd2,
        REG_WIN_HEIGHT    = 3'd3,
        REG_CORNER_RADIUS = 3'd4,
        REG_FILL_COLOR    = 3'd5,
        REG_EDGE_COLOR    = 3'd6
    } cfg_reg_t;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [RADIUS_W-1:0] radius_t;
    typedef logic [COLOR_W-1:0]  color_t;

endpackage

[sv/rounded_window_pixel_shader_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_window_pixel_shader_top
// Decides for each pixel whether one rounded-corner window covers it and
// returns the edge or fill color, through a four-stage pipeline.
// ----------------------------------------------------------------------------
// Pipeline: a pixel accepted with start moves through the stage 1, stage 2,
// stage 3 and stage 4 registers; its result is then on the outputs for one
// cycle, with done high.
// Throughput: one pixel per clock; busy is always low, since every stage
// advances on every cycle and the receiver cannot stall.
// Reset: rst_n clears all configuration registers to zero and empties the
// pipeline; no result strobe follows reset until a pixel is accepted.
module rounded_window_pixel_shader_top #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1200
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Pixel command channel.
    input  logic                           start,
    output logic                           busy,
    input  logic [rwps_pkg::COORD_W-1:0]   pixel_x,
    input  logic [rwps_pkg::COORD_W-1:0]   pixel_y,
    // Result channel.
    output logic                           done,
    output logic                           covered,
    output logic [rwps_pkg::COLOR_W-1:0]   pixel_color,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [rwps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rwps_pkg::COLOR_W-1:0]   cfg_data
);

    localparam logic [rwps_pkg::COORD_W:0] SCR_W = (rwps_pkg::COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [rwps_pkg::COORD_W:0] SCR_H = (rwps_pkg::COORD_W+1)'(SCREEN_HEIGHT);
    localparam int PROD_W = 2 * rwps_pkg::RADIUS_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    rwps_pkg::coord_t  win_left_reg;
    rwps_pkg::coord_t  win_top_reg;
    rwps_pkg::coord_t  win_width_reg;
    rwps_pkg::coord_t  win_height_reg;
    rwps_pkg::radius_t corner_radius_reg;
    rwps_pkg::color_t  fill_color_reg;
    rwps_pkg::color_t  edge_color_reg;

    // A write transfer updates the addressed register; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg      <= '0;
            win_top_reg       <= '0;
            win_width_reg     <= '0;
            win_height_reg    <= '0;
            corner_radius_reg <= '0;
            fill_color_reg    <= '0;
            edge_color_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (rwps_pkg::cfg_reg_t'(cfg_index))
                rwps_pkg::REG_WIN_LEFT:      win_left_reg      <= cfg_data[rwps_pkg::COORD_W-1:0];
                rwps_pkg::REG_WIN_TOP:       win_top_reg       <= cfg_data[rwps_pkg::COORD_W-1:0];
                rwps_pkg::REG_WIN_WIDTH:     win_width_reg     <= cfg_data[rwps_pkg::COORD_W-1:0];
                rwps_pkg::REG_WIN_HEIGHT:    win_height_reg    <= cfg_data[rwps_pkg::COORD_W-1:0];
                rwps_pkg::REG_CORNER_RADIUS: corner_radius_reg <= cfg_data[rwps_pkg::RADIUS_W-1:0];
                rwps_pkg::REG_FILL_COLOR:    fill_color_reg    <= cfg_data;
                rwps_pkg::REG_EDGE_COLOR:    edge_color_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline never holds off a new pixel.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: window offsets, bounds checks and clamped radius.
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_inb_reg;
    logic              s1_inb_next;
    rwps_pkg::coord_t  s1_u_reg;
    rwps_pkg::coord_t  s1_u_next;
    rwps_pkg::coord_t  s1_v_reg;
    rwps_pkg::coord_t  s1_v_next;
    rwps_pkg::radius_t s1_r_reg;
    rwps_pkg::radius_t s1_r_next;

    rwps_pkg::radius_t half_w;
    rwps_pkg::radius_t half_h;
    rwps_pkg::radius_t r_clamp_w;

    // Clamp the radius to half the width, then to half the height.
    always_comb
    begin
        half_w    = win_width_reg[rwps_pkg::COORD_W-1:1];
        half_h    = win_height_reg[rwps_pkg::COORD_W-1:1];
        r_clamp_w = (corner_radius_reg > half_w) ? half_w : corner_radius_reg;
        s1_r_next = (r_clamp_w > half_h) ? half_h : r_clamp_w;
    end

    // The pixel must be on screen, right of and below the window origin,
    // and the window must be wider and taller than two pixels.
    always_comb
    begin
        s1_valid_next = start && !busy;
        s1_u_next     = pixel_x - win_left_reg;
        s1_v_next     = pixel_y - win_top_reg;
        s1_inb_next   = (win_width_reg > rwps_pkg::COORD_W'(2))
                     && (win_height_reg > rwps_pkg::COORD_W'(2))
                     && ({1'b0, pixel_x} < SCR_W)
                     && ({1'b0, pixel_y} < SCR_H)
                     && (pixel_x >= win_left_reg)
                     && (pixel_y >= win_top_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_inb_reg <= s1_inb_next;
        s1_u_reg   <= s1_u_next;
        s1_v_reg   <= s1_v_next;
        s1_r_reg   <= s1_r_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: region classification and corner offsets.
    // ------------------------------------------------------------------
    logic              s2_valid_reg;
    logic              s2_in_reg;
    logic              s2_in_next;
    logic              s2_sq_edge_reg;
    logic              s2_sq_edge_next;
    logic              s2_r0_reg;
    logic              s2_r0_next;
    logic              s2_xo_reg;
    logic              s2_xo_next;
    logic              s2_yo_reg;
    logic              s2_yo_next;
    rwps_pkg::radius_t s2_dx_reg;
    rwps_pkg::radius_t s2_dx_next;
    rwps_pkg::radius_t s2_dy_reg;
    rwps_pkg::radius_t s2_dy_next;
    rwps_pkg::radius_t s2_r_reg;

    rwps_pkg::coord_t  r_wide;
    rwps_pkg::coord_t  w_last;
    rwps_pkg::coord_t  h_last;
    rwps_pkg::coord_t  i_off;
    rwps_pkg::coord_t  j_off;

    // Square-corner edge test, edge band membership, and distance of the
    // pixel from the inner corner of its corner square.
    always_comb
    begin
        r_wide     = rwps_pkg::COORD_W'(s1_r_reg);
        w_last     = win_width_reg - rwps_pkg::COORD_W'(1);
        h_last     = win_height_reg - rwps_pkg::COORD_W'(1);
        s2_in_next = s1_inb_reg && (s1_u_reg < win_width_reg) && (s1_v_reg < win_height_reg);
        s2_r0_next = (s1_r_reg == '0);
        s2_sq_edge_next = (s1_u_reg == '0) || (s1_v_reg == '0)
                       || (s1_u_reg == w_last) || (s1_v_reg == h_last);
        s2_xo_next = (s1_u_reg < r_wide) || (s1_u_reg >= (win_width_reg - r_wide));
        s2_yo_next = (s1_v_reg < r_wide) || (s1_v_reg >= (win_height_reg - r_wide));
        i_off      = (s1_u_reg < r_wide) ? s1_u_reg : (w_last - s1_u_reg);
        j_off      = (s1_v_reg < r_wide) ? s1_v_reg : (h_last - s1_v_reg);
        s2_dx_next = s1_r_reg - rwps_pkg::RADIUS_W'(1) - i_off[rwps_pkg::RADIUS_W-1:0];
        s2_dy_next = s1_r_reg - rwps_pkg::RADIUS_W'(1) - j_off[rwps_pkg::RADIUS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_in_reg      <= s2_in_next;
        s2_sq_edge_reg <= s2_sq_edge_next;
        s2_r0_reg      <= s2_r0_next;
        s2_xo_reg      <= s2_xo_next;
        s2_yo_reg      <= s2_yo_next;
        s2_dx_reg      <= s2_dx_next;
        s2_dy_reg      <= s2_dy_next;
        s2_r_reg       <= s1_r_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: squares of the corner offsets and of the radius.
    // ------------------------------------------------------------------
    logic                s3_valid_reg;
    logic                s3_in_reg;
    logic                s3_sq_edge_reg;
    logic                s3_r0_reg;
    logic                s3_xo_reg;
    logic                s3_yo_reg;
    logic [PROD_W-1:0]   s3_dx2_reg;
    logic [PROD_W-1:0]   s3_dx2_next;
    logic [PROD_W-1:0]   s3_dy2_reg;
    logic [PROD_W-1:0]   s3_dy2_next;
    logic [PROD_W-1:0]   s3_rr_reg;
    logic [PROD_W-1:0]   s3_rr_next;

    always_comb
    begin
        s3_dx2_next = PROD_W'(s2_dx_reg) * PROD_W'(s2_dx_reg);
        s3_dy2_next = PROD_W'(s2_dy_reg) * PROD_W'(s2_dy_reg);
        s3_rr_next  = PROD_W'(s2_r_reg) * PROD_W'(s2_r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_in_reg      <= s2_in_reg;
        s3_sq_edge_reg <= s2_sq_edge_reg;
        s3_r0_reg      <= s2_r0_reg;
        s3_xo_reg      <= s2_xo_reg;
        s3_yo_reg      <= s2_yo_reg;
        s3_dx2_reg     <= s3_dx2_next;
        s3_dy2_reg     <= s3_dy2_next;
        s3_rr_reg      <= s3_rr_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: corner distance compare and color selection.
    // ------------------------------------------------------------------
    logic              done_reg;
    logic              covered_reg;
    logic              covered_next;
    rwps_pkg::color_t  pixel_color_reg;
    rwps_pkg::color_t  pixel_color_next;

    logic [PROD_W:0]   dist2;
    logic              use_edge;

    // Pick edge or fill color; uncovered pixels report zero.
    always_comb
    begin
        dist2 = {1'b0, s3_dx2_reg} + {1'b0, s3_dy2_reg};
        if (s3_r0_reg)
        begin
            use_edge = s3_sq_edge_reg;
        end
        else if (s3_xo_reg && s3_yo_reg)
        begin
            use_edge = (dist2 >= {1'b0, s3_rr_reg});
        end
        else
        begin
            use_edge = s3_xo_reg || s3_yo_reg;
        end
        covered_next     = s3_in_reg;
        pixel_color_next = !s3_in_reg ? '0 : (use_edge ? edge_color_reg : fill_color_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        covered_reg     <= covered_next;
        pixel_color_reg <= pixel_color_next;
    end

    assign done        = done_reg;
    assign covered     = covered_reg;
    assign pixel_color = pixel_color_reg;

endmodule

[tb/sv/rwps_shade_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwps_shade_checker
// Watches the pixel, result and configuration channels of the rounded window
// pixel shader. It keeps its own copy of the window registers, predicts the
// coverage and color of every accepted pixel, and compares each result
// transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module rwps_shade_checker #(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1200
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [rwps_pkg::COORD_W-1:0]   pixel_x,
    input  logic [rwps_pkg::COORD_W-1:0]   pixel_y,
    input  logic                           done,
    input  logic                           covered,
    input  logic [rwps_pkg::COLOR_W-1:0]   pixel_color,
    input  logic                           cfg_we,
    input  logic [rwps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rwps_pkg::COLOR_W-1:0]   cfg_data,
    output int                             mismatch_count,
    output int                             pending_count,
    output int                             checked_count,
    output int                             covered_count
);

    typedef struct packed {
        logic             covered;
        rwps_pkg::color_t color;
    } shade_t;

    // Shadow copy of the window registers.
    rwps_pkg::coord_t  win_left;
    rwps_pkg::coord_t  win_top;
    rwps_pkg::coord_t  win_width;
    rwps_pkg::coord_t  win_height;
    rwps_pkg::radius_t corner_radius;
    rwps_pkg::color_t  fill_color;
    rwps_pkg::color_t  edge_color;

    shade_t expected_shades[$];
    shade_t seen_shade;
    shade_t oldest_shade;

    // Coverage and color of one pixel under the current window.
    function automatic shade_t shade_pixel(rwps_pkg::coord_t px, rwps_pkg::coord_t py);
        shade_t      res;
        int unsigned w;
        int unsigned h;
        int unsigned u;
        int unsigned v;
        int unsigned r;
        int unsigned i;
        int unsigned j;
        int unsigned dx;
        int unsigned dy;
        logic        x_band;
        logic        y_band;
        res.covered = 1'b0;
        res.color   = '0;
        w = win_width;
        h = win_height;
        if (w <= 2 || h <= 2)
            return res;
        if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)
            return res;
        if (px < win_left || py < win_top)
            return res;
        u = px - win_left;
        v = py - win_top;
        if (u >= w || v >= h)
            return res;
        res.covered = 1'b1;
        r = corner_radius;
        if (r == 0) begin
            // Square corners: a one-pixel outer ring.
            if (u == 0 || v == 0 || u == w - 1 || v == h - 1)
                res.color = edge_color;
            else
                res.color = fill_color;
        end else begin
            if (r > w / 2)
                r = w / 2;
            if (r > h / 2)
                r = h / 2;
            x_band = (u < r) || (u >= w - r);
            y_band = (v < r) || (v >= h - r);
            if (x_band && y_band) begin
                // Corner square: distance from the inner corner decides.
                i  = (u < r) ? u : (w - 1 - u);
                j  = (v < r) ? v : (h - 1 - v);
                dx = r - 1 - i;
                dy = r - 1 - j;
                res.color = (dx * dx + dy * dy >= r * r) ? edge_color : fill_color;
            end else if (x_band || y_band) begin
                res.color = edge_color;
            end else begin
                res.color = fill_color;
            end
        end
        return res;
    endfunction

    // Counts a failure and prints the first few.
    task automatic report_mismatch(string what, shade_t want, shade_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected covered=%0b color=%08h, got covered=%0b color=%08h",
                     what, want.covered, want.color, got.covered, got.color);
    endtask

    // Check result transfers, record accepted pixels, track register writes.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win_left       = '0;
            win_top        = '0;
            win_width      = '0;
            win_height     = '0;
            corner_radius  = '0;
            fill_color     = '0;
            edge_color     = '0;
            mismatch_count = 0;
            checked_count  = 0;
            covered_count  = 0;
            expected_shades.delete();
        end else begin
            if (done) begin
                seen_shade.covered = covered;
                seen_shade.color   = pixel_color;
                if (expected_shades.size() == 0) begin
                    report_mismatch("result with no pixel pending", '0, seen_shade);
                end else begin
                    oldest_shade = expected_shades.pop_front();
                    checked_count++;
                    if (oldest_shade.covered)
                        covered_count++;
                    if (seen_shade.covered !== oldest_shade.covered ||
                        seen_shade.color !== oldest_shade.color)
                        report_mismatch("pixel result mismatch", oldest_shade, seen_shade);
                end
            end
            if (start && !busy)
                expected_shades.push_back(shade_pixel(pixel_x, pixel_y));
            if (cfg_we) begin
                case (rwps_pkg::cfg_reg_t'(cfg_index))
                    rwps_pkg::REG_WIN_LEFT: win_left = cfg_data[rwps_pkg::COORD_W-1:0];
                    rwps_pkg::REG_WIN_TOP: win_top = cfg_data[rwps_pkg::COORD_W-1:0];
                    rwps_pkg::REG_WIN_WIDTH: win_width = cfg_data[rwps_pkg::COORD_W-1:0];
                    rwps_pkg::REG_WIN_HEIGHT: win_height = cfg_data[rwps_pkg::COORD_W-1:0];
                    rwps_pkg::REG_CORNER_RADIUS:
                        corner_radius = cfg_data[rwps_pkg::RADIUS_W-1:0];
                    rwps_pkg::REG_FILL_COLOR: fill_color = cfg_data;
                    rwps_pkg::REG_EDGE_COLOR: edge_color = cfg_data;
                    default: ;
                endcase
            end
        end
        pending_count = expected_shades.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Top level for the rounded window pixel shader. It resets the block, sets
// up a series of windows (thin, square-cornered, rounded, clamped radius,
// straddling the screen bounds, full size) and streams pixels at each of
// them, mostly with random gaps, while the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1200;
    localparam int CYCLE_LIMIT   = 200000;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    rwps_pkg::coord_t pixel_x;
    rwps_pkg::coord_t pixel_y;
    logic   done;
    logic   covered;
    rwps_pkg::color_t pixel_color;
    logic   cfg_we;
    logic [rwps_pkg::CFG_IDX_W-1:0] cfg_index;
    rwps_pkg::color_t cfg_data;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int covered_count;
    int cycle_count;
    int window_count;
    bit gaps_on;

    // Current window, used to aim pixels near it.
    int unsigned cur_left;
    int unsigned cur_top;
    int unsigned cur_width;
    int unsigned cur_height;

    rounded_window_pixel_shader_top #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .done        (done),
        .covered     (covered),
        .pixel_color (pixel_color),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    rwps_shade_checker #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) shade_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .done           (done),
        .covered        (covered),
        .pixel_color    (pixel_color),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .covered_count  (covered_count)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // One register write; the enable stays high until the caller lowers it.
    task automatic write_reg(rwps_pkg::cfg_reg_t idx, rwps_pkg::color_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Waits for every pending result, then writes all window registers.
    // With junk set, bits above each register's width carry random values.
    task automatic set_window(int unsigned left, int unsigned top, int unsigned width,
                              int unsigned height, int unsigned radius,
                              rwps_pkg::color_t fill, rwps_pkg::color_t edge_c, bit junk);
        rwps_pkg::color_t hi12;
        rwps_pkg::color_t hi11;
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        hi12 = junk ? ($urandom & 32'hFFFF_F000) : '0;
        hi11 = junk ? ($urandom & 32'hFFFF_F800) : '0;
        write_reg(rwps_pkg::REG_WIN_LEFT, hi12 | (left & 32'hFFF));
        write_reg(rwps_pkg::REG_WIN_TOP, hi12 | (top & 32'hFFF));
        write_reg(rwps_pkg::REG_WIN_WIDTH, hi12 | (width & 32'hFFF));
        write_reg(rwps_pkg::REG_WIN_HEIGHT, hi12 | (height & 32'hFFF));
        write_reg(rwps_pkg::REG_CORNER_RADIUS, hi11 | (radius & 32'h7FF));
        write_reg(rwps_pkg::REG_FILL_COLOR, fill);
        write_reg(rwps_pkg::REG_EDGE_COLOR, edge_c);
        cfg_we     <= 1'b0;
        cur_left   = left & 32'hFFF;
        cur_top    = top & 32'hFFF;
        cur_width  = width & 32'hFFF;
        cur_height = height & 32'hFFF;
        window_count++;
    endtask

    // Offers one pixel, with an occasional gap first, and waits for the transfer.
    task automatic send_pixel(int unsigned x, int unsigned y);
        while (gaps_on && $urandom_range(99, 0) < 15)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        pixel_x <= x[rwps_pkg::COORD_W-1:0];
        pixel_y <= y[rwps_pkg::COORD_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // A coordinate within a few pixels of the span [base, base + len).
    function automatic int unsigned near_coord(int unsigned base, int unsigned len);
        int unsigned lo;
        int unsigned hi;
        lo = (base >= 4) ? base - 4 : 0;
        hi = base + len + 4;
        if (hi > 4095)
            hi = 4095;
        if (lo > hi)
            lo = hi;
        return $urandom_range(hi, lo);
    endfunction

    // Main stimulus sequence.
    initial
    begin
        int unsigned items;
        int unsigned w;
        int unsigned h;
        int unsigned r;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel_x      = '0;
        pixel_y      = '0;
        cfg_we       = 1'b0;
        cfg_index    = rwps_pkg::REG_WIN_LEFT;
        cfg_data     = '0;
        cycle_count  = 0;
        window_count = 0;
        gaps_on      = 1'b1;
        cur_left     = 0;
        cur_top      = 0;
        cur_width    = 0;
        cur_height   = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at their reset values: a zero-size window covers nothing.
        send_pixel(0, 0);
        send_pixel(4095, 4095);

        // Square corners: one-pixel edge ring.
        set_window(10, 20, 8, 6, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        send_pixel(10, 20);
        send_pixel(11, 21);
        send_pixel(17, 25);
        send_pixel(18, 20);
        send_pixel(9, 20);
        send_pixel(13, 26);

        // Largest radius, clamped to half the width and then half the height.
        set_window(100, 100, 20, 14, 2047, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_pixel(100, 100);
        send_pixel(102, 103);
        send_pixel(106, 106);
        send_pixel(119, 113);
        send_pixel(110, 100);

        // Window running past the screen corner.
        set_window(1900, 1190, 4095, 4095, 5, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_pixel(1919, 1199);
        send_pixel(1920, 1199);
        send_pixel(1919, 1200);
        send_pixel(4095, 4095);

        // Smallest window that draws, then a thin one that does not.
        set_window(0, 0, 3, 3, 1, 32'h1234_5678, 32'h8765_4321, 1'b0);
        send_pixel(1, 1);
        send_pixel(0, 0);
        set_window(0, 0, 2, 100, 0, 32'h1234_5678, 32'h8765_4321, 1'b0);
        send_pixel(1, 1);

        // Random windows, with pixels aimed mostly at and around each one.
        for (int phase = 0; phase < 10; phase++)
        begin
            items   = 40;
            gaps_on = 1'b1;
            case (phase)
                0: set_window(0, 0, 4095, 4095, 2047, $urandom, $urandom, 1'b1);
                1: set_window($urandom_range(1919, 1850), $urandom_range(1199, 1150),
                              4095, 4095, $urandom_range(2047, 0), $urandom, $urandom, 1'b1);
                2: set_window(4095, 4095, $urandom_range(4095, 0), $urandom_range(4095, 0),
                              $urandom_range(2047, 0), $urandom, $urandom, 1'b1);
                3: set_window($urandom_range(1880, 0), $urandom_range(1180, 0),
                              $urandom_range(2, 0), $urandom_range(40, 3),
                              $urandom_range(8, 0), $urandom, $urandom, 1'b1);
                default:
                begin
                    w = $urandom_range(64, 3);
                    h = $urandom_range(64, 3);
                    case ($urandom_range(3, 0))
                        0: r = 0;
                        1: r = 2047;
                        default: r = $urandom_range(40, 1);
                    endcase
                    set_window($urandom_range(1880, 0), $urandom_range(1180, 0), w, h, r,
                               $urandom, $urandom, 1'b1);
                end
            endcase
            // One long stretch with no gaps at all.
            if (phase == 5)
            begin
                gaps_on = 1'b0;
                items   = 80;
            end
            for (int n = 0; n < items; n++)
            begin
                if (phase == 0 || $urandom_range(99, 0) < 20)
                    send_pixel($urandom_range(4095, 0), $urandom_range(4095, 0));
                else
                    send_pixel(near_coord(cur_left, cur_width),
                               near_coord(cur_top, cur_height));
            end
        end

        // Drain the pipeline.
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Shaded %0d pixels across %0d window settings; %0d were covered.",
                 checked_count, window_count, covered_count);
        $display("Mismatches: %0d.", mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[rounded_window_pixel_shader_top.f]
sv/rwps_pkg.sv
sv/rounded_window_pixel_shader_top.sv
tb/sv/rwps_shade_checker.sv
tb/sv/testbench.sv
